### rtl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

  // timestamp counter width, pulse lengths wrap at this width
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned FRAME_W    = 40;
  localparam int unsigned BITCNT_W   = 6;
  localparam int unsigned TEMP_W     = 17;
  localparam int unsigned HUM_W      = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [THRESH_W-1:0] THRESH_RST  = 16'd1200;
  localparam logic [BITCNT_W-1:0] FRAME_BITS  = 6'd40;

  // event kinds
  typedef enum logic [1:0] {
    MODE_START      = 2'd0,
    MODE_PAUSE_DONE = 2'd1,
    MODE_EDGE       = 2'd2,
    MODE_TIMEOUT    = 2'd3
  } mode_e;

  // read sequence phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PAUSE     = 3'd1,
    PH_RESP_LOW  = 3'd2,
    PH_INIT_HIGH = 3'd3,
    PH_INIT_LOW  = 3'd4,
    PH_DATA_HIGH = 3'd5,
    PH_DATA_LOW  = 3'd6
  } phase_e;

  // data line control
  typedef enum logic [1:0] {
    DRIVE_HIGH    = 2'd0,
    DRIVE_LOW     = 2'd1,
    DRIVE_RELEASE = 2'd2
  } drive_e;

  // completion status
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CKSUM   = 2'd1,
    STAT_TIMEOUT = 2'd2
  } status_e;

  typedef struct packed {
    mode_e            mode;
    logic             level;
    logic [CNT_W-1:0] edge_time;
  } item_t;

  typedef struct packed {
    drive_e            line_drive;
    logic              done;
    status_e           status;
    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;
    logic              online;
  } result_t;

endpackage

### rtl/sfd_frame_check.sv
`timescale 1ns / 1ps

module sfd_frame_check (
  input  logic [sfd_pkg::FRAME_W-1:0] frame_i,
  output logic                        sum_ok_o,
  output logic [sfd_pkg::TEMP_W-1:0]  temp_o,
  output logic [sfd_pkg::HUM_W-1:0]   hum_o
);
  import sfd_pkg::*;

  // ceil(2^22 / 5), exact quotient for any dividend below 2^22
  localparam logic [19:0] RECIP_5 = 20'd838861;
  localparam logic [TEMP_W-1:0] TEMP_OFS = 17'd320;

  logic [7:0]  h1, h0, t1, t0, ck, sum;
  logic [15:0] raw;
  logic [19:0] raw9;
  logic [39:0] prod;

  // frame bytes, most significant first
  assign h1 = frame_i[39:32];
  assign h0 = frame_i[31:24];
  assign t1 = frame_i[23:16];
  assign t0 = frame_i[15:8];
  assign ck = frame_i[7:0];

  // 8-bit wrapping checksum
  assign sum      = h1 + h0 + t1 + t0;
  assign sum_ok_o = (sum == ck);

  // raw * 9 / 5 + 320, division by reciprocal multiply
  assign raw    = {t1, t0};
  assign raw9   = {1'b0, raw, 3'b000} + {4'b0000, raw};
  assign prod   = raw9 * RECIP_5;
  assign temp_o = prod[38:22] + TEMP_OFS;
  assign hum_o  = {h1, h0};

endmodule

### rtl/sfd_core.sv
`timescale 1ns / 1ps

module sfd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  sfd_pkg::item_t               item_i,
  input  logic [sfd_pkg::THRESH_W-1:0] threshold_i,
  output sfd_pkg::result_t             result_o
);
  import sfd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [FRAME_W-1:0]  frame_q, frame_d, frame_shift;
  logic [BITCNT_W-1:0] bit_cnt_q, bit_cnt_d, bit_cnt_inc;
  logic [CNT_W-1:0]    start_q, start_d, delta;
  logic [TEMP_W-1:0]   temp_q, temp_d, chk_temp;
  logic [HUM_W-1:0]    hum_q, hum_d, chk_hum;
  logic                online_q, online_d, chk_ok;
  logic                done;
  status_e             status;
  drive_e              drive;

  // pulse length and shifted frame for the data-low edge
  assign delta       = item_i.edge_time - start_q;
  assign frame_shift = {frame_q[FRAME_W-2:0], (delta > threshold_i)};
  assign bit_cnt_inc = bit_cnt_q + 1'b1;

  sfd_frame_check u_check (
    .frame_i  (frame_shift),
    .sum_ok_o (chk_ok),
    .temp_o   (chk_temp),
    .hum_o    (chk_hum)
  );

  // next state for one event
  always_comb begin
    phase_d   = phase_q;
    frame_d   = frame_q;
    bit_cnt_d = bit_cnt_q;
    start_d   = start_q;
    temp_d    = temp_q;
    hum_d     = hum_q;
    online_d  = online_q;
    done      = 1'b0;
    status    = STAT_OK;
    case (item_i.mode)
      MODE_START: begin
        frame_d   = '0;
        bit_cnt_d = '0;
        phase_d   = PH_PAUSE;
      end
      MODE_PAUSE_DONE: begin
        if (phase_q == PH_PAUSE) phase_d = PH_RESP_LOW;
      end
      MODE_EDGE: begin
        case (phase_q)
          PH_RESP_LOW: begin
            if (!item_i.level) phase_d = PH_INIT_HIGH;
          end
          PH_INIT_HIGH: phase_d = PH_INIT_LOW;
          PH_INIT_LOW: begin
            bit_cnt_d = '0;
            phase_d   = PH_DATA_HIGH;
          end
          PH_DATA_HIGH: begin
            start_d = item_i.edge_time;
            phase_d = PH_DATA_LOW;
          end
          PH_DATA_LOW: begin
            frame_d   = frame_shift;
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= FRAME_BITS) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              if (chk_ok) begin
                temp_d   = chk_temp;
                hum_d    = chk_hum;
                online_d = 1'b1;
                status   = STAT_OK;
              end else begin
                online_d = 1'b0;
                status   = STAT_CKSUM;
              end
            end else begin
              phase_d = PH_DATA_HIGH;
            end
          end
          default: ;
        endcase
      end
      MODE_TIMEOUT: begin
        if (phase_q != PH_IDLE) begin
          phase_d  = PH_IDLE;
          online_d = 1'b0;
          done     = 1'b1;
          status   = STAT_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  // line control follows the new phase
  always_comb begin
    case (phase_d)
      PH_IDLE:  drive = DRIVE_HIGH;
      PH_PAUSE: drive = DRIVE_LOW;
      default:  drive = DRIVE_RELEASE;
    endcase
  end

  assign result_o = '{line_drive: drive, done: done, status: status,
                      temp: temp_d, hum: hum_d, online: online_d};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      frame_q   <= '0;
      bit_cnt_q <= '0;
      start_q   <= '0;
      temp_q    <= '0;
      hum_q     <= '0;
      online_q  <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      frame_q   <= frame_d;
      bit_cnt_q <= bit_cnt_d;
      start_q   <= start_d;
      temp_q    <= temp_d;
      hum_q     <= hum_d;
      online_q  <= online_d;
    end
  end

endmodule

### rtl/single_wire_sensor_frame_decoder.sv
`timescale 1ns / 1ps
// Single-wire temperature/humidity sensor frame decoder.
// Input stream: one event per transaction. tuser carries the event kind
// (start, pause done, line edge, timeout); tdata carries the line level and
// the timer value captured at the edge.
// Output stream: exactly one result transaction per input event, giving the
// line control, a done flag with status, the last good temperature (tenths
// of a degree F), humidity (tenths of a percent) and the online flag.
// The one-bit pulse threshold is written through cfg_wr_en_i/cfg_wr_data_i
// while no event is in flight; the user must keep to this, the block does not enforce it.
// An accepted event is held in the input register, then decoded into the
// result register, which holds it until the output is taken.
// Throughput: one event per cycle while the output is not stalled; the decode,
// checksum and temperature conversion (one 20x20 multiply) run in the single
// stage between the input register and the result register.
// Reset clears the sequencer to idle, the stored readings, the online flag
// and both stage valids; the threshold returns to 1200 ticks.
// When the receiver stalls, the result holds and the input register still
// takes one more event; then s_axis_tready_o drops until the result is taken.
module single_wire_sensor_frame_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_wr_en_i,
  input  logic [sfd_pkg::THRESH_W-1:0]   cfg_wr_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [0] line_level, [16:1] edge_time, [23:17] zero
  input  logic [sfd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] mode
  input  logic [sfd_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] line_drive, [18:2] temperature_tenths_f, [34:19] humidity_tenths,
  // [35] sensor_online, [39:36] zero
  output logic [sfd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] done_res, [2:1] status
  output logic [sfd_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);
  import sfd_pkg::*;

  logic [THRESH_W-1:0] thresh_q;
  logic                in_valid_q, out_valid_q, advance;
  item_t               in_item_q, in_item_d;
  result_t             res_d, res_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
    end else if (cfg_wr_en_i) begin
      thresh_q <= cfg_wr_data_i;
    end
  end

  // stage handshake
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign in_item_d = '{mode: mode_e'(s_axis_tuser_i[1:0]), level: s_axis_tdata_i[0],
                       edge_time: s_axis_tdata_i[CNT_W:1]};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= in_item_d;
    end
  end

  sfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (in_item_q),
    .threshold_i (thresh_q),
    .result_o    (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.online, res_q.hum, res_q.temp, res_q.line_drive};
  assign m_axis_tuser_o  = {res_q.status, res_q.done};

`ifndef NO_ASSERTIONS
  // status is only meaningful on a finished attempt
  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tuser_o[2:1] == STAT_OK)
    else $error("status set without done");

  // a good frame marks the sensor online
  a_ok_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] && m_axis_tuser_o[2:1] == STAT_OK
    |-> m_axis_tdata_o[35])
    else $error("good frame without online flag");

  // a timeout leaves the sensor offline and the line driven high
  a_timeout_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2:1] == STAT_TIMEOUT
    |-> !m_axis_tdata_o[35] && m_axis_tdata_o[1:0] == DRIVE_HIGH)
    else $error("timeout result inconsistent");

  // both stages full and stalled: no new transaction accepted
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while pipeline full");
`endif

endmodule
